// File: design/cgr_pkg.sv
// Package for the color gradient ramp: constants, register codes, stage types.
package cgr_pkg;

    // Geometry of the ramp
    localparam int NUM_STOPS = 5;
    localparam int FRAC_BITS = 8;
    localparam int NUM_CH    = 3;
    localparam int CH_W      = 8;
    localparam int POS_W     = 9;
    localparam int STOP_W    = POS_W + NUM_CH * CH_W;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int UPOS_W = POS_W + 1;
    localparam int SPAN_W = POS_W + 2;
    localparam int DEN_W  = POS_W + 1;
    localparam int PROD_W = POS_W + CH_W + 2;
    localparam int REM_W  = PROD_W;
    localparam int QUO_W  = CH_W;
    localparam int HALF_Q = QUO_W / 2;

    // Implicit stop above the first one: 1.0, black
    localparam logic [UPOS_W-1:0] ONE_POS = UPOS_W'(1 << FRAC_BITS);

    // Channel order: red, green, blue
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT = 3'd0,
        REG_STOP_ZERO  = 3'd1,
        REG_STOP_ONE   = 3'd2,
        REG_STOP_TWO   = 3'd3,
        REG_STOP_THREE = 3'd4,
        REG_STOP_FOUR  = 3'd5
    } cfg_reg_t;

    localparam logic [CNT_W-1:0] STOP_COUNT_RESET = CNT_W'(NUM_STOPS);

    // Default fire ramp
    localparam logic [STOP_W-1:0] STOP_RESET [NUM_STOPS] = '{
        33'd4311744511, 33'd3875504128, 33'd3019833344, 33'd2153381945, 33'd436207616
    };

    typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

    // Stage 1: selected segment
    typedef struct packed {
        logic                     matched;
        logic                     direct;
        logic [POS_W-1:0]         t;
        logic signed [SPAN_W-1:0] span;
        rgb_t                     lower;
        rgb_t                     upper;
    } s1_t;

    // Stage 2: partial products
    typedef struct packed {
        logic                           matched;
        logic                           direct;
        rgb_t                           lower;
        logic signed [SPAN_W-1:0]       span;
        logic [NUM_CH-1:0][PROD_W-1:0]  p_slope;
        logic [NUM_CH-1:0][PROD_W-1:0]  p_base;
    } s2_t;

    // Stage 3: magnitudes for the divider
    typedef struct packed {
        logic                           matched;
        logic                           direct;
        rgb_t                           lower;
        logic [NUM_CH-1:0]              zero;
        logic [NUM_CH-1:0][REM_W-1:0]   num;
        logic [DEN_W-1:0]               den;
    } s3_t;

    // Stage 4: upper quotient bits done
    typedef struct packed {
        logic                           matched;
        logic                           direct;
        rgb_t                           lower;
        logic [NUM_CH-1:0]              zero;
        logic [NUM_CH-1:0]              over;
        logic [NUM_CH-1:0][REM_W-1:0]   rem;
        logic [NUM_CH-1:0][HALF_Q-1:0]  quo_hi;
        logic [DEN_W-1:0]               den;
    } s4_t;

    // Color field of a packed stop
    function automatic logic [CH_W-1:0] stop_color(input logic [STOP_W-1:0] stop, input int ch);
        return stop[(NUM_CH - 1 - ch) * CH_W +: CH_W];
    endfunction

    function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] stop);
        return stop[STOP_W-1 -: POS_W];
    endfunction

endpackage

// File: design/color_gradient_ramp.sv
// Color gradient ramp: stop lookup, linear interpolation and floor divide, five stages.
//
// Usage:
//   Input words (s_ratio, s_prev_*) enter on s_valid/s_ready; a ratio in Q1.8
//   selects the first configured stop at or below it, and each channel is
//   interpolated toward the stop above (black at 1.0 above stop zero).
//   Result words (m_red, m_green, m_blue, m_matched) leave on m_valid/m_ready.
//   With no matching stop the previous color passes through, m_matched = 0.
//   Throughput is one word per cycle while m_ready does not stall the
//   output; the five register stages are select, multiply, add and
//   magnitude, and two restoring-divide stages of four quotient bits each.
//   A stalled m_ready holds the output word; each stage keeps accepting
//   while any later stage has a free slot, so bubbles are squeezed out.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; index 0 is stop_count, 1..5 the packed stops, others are ignored.
//   Write it only while the pipeline is empty.
//   Reset (aresetn low, synchronous) empties the pipeline and loads
//   stop_count = 5 with the default fire ramp.
module color_gradient_ramp
    import cgr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [POS_W-1:0]     s_ratio,
    input  logic [CH_W-1:0]      s_prev_red,
    input  logic [CH_W-1:0]      s_prev_green,
    input  logic [CH_W-1:0]      s_prev_blue,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CH_W-1:0]      m_red,
    output logic [CH_W-1:0]      m_green,
    output logic [CH_W-1:0]      m_blue,
    output logic                 m_matched,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STOP_W-1:0]    cfg_data
);

    localparam int NSTG = 5;

    logic [CNT_W-1:0]  stop_count_reg;
    logic [STOP_W-1:0] stop_reg [NUM_STOPS];

    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   rdy;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    rgb_t out_rgb_reg, out_rgb_next;
    logic out_matched_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= STOP_COUNT_RESET;
            for (int i = 0; i < NUM_STOPS; i++) begin
                stop_reg[i] <= STOP_RESET[i];
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_STOP_COUNT) begin
                stop_count_reg <= cfg_data[CNT_W-1:0];
            end
            for (int i = 0; i < NUM_STOPS; i++) begin
                if (cfg_index == CFG_IDX_W'(i + 1)) begin
                    stop_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Ready chain: a stage moves when it is empty or its successor moves
    always_comb begin
        rdy[NSTG] = m_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k + 1];
        end
    end

    assign s_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    // Stage 1: find the first stop at or below the ratio
    always_comb begin
        logic [CNT_W-1:0]  cnt_lim;
        logic [POS_W-1:0]  pos;
        logic [UPOS_W-1:0] up_pos;
        rgb_t              up_rgb;
        rgb_t              lo_rgb;
        cnt_lim = (stop_count_reg > CNT_W'(NUM_STOPS)) ? CNT_W'(NUM_STOPS) : stop_count_reg;
        s1_next.matched = 1'b0;
        s1_next.direct  = 1'b1;
        s1_next.t       = '0;
        s1_next.span    = '0;
        s1_next.upper   = '0;
        s1_next.lower[CH_RED]   = s_prev_red;
        s1_next.lower[CH_GREEN] = s_prev_green;
        s1_next.lower[CH_BLUE]  = s_prev_blue;
        // descending scan so the lowest index that hits wins
        for (int i = NUM_STOPS - 1; i >= 0; i--) begin
            pos = stop_pos(stop_reg[i]);
            if (i == 0) begin
                up_pos = ONE_POS;
                up_rgb = '0;
            end else begin
                up_pos = {1'b0, stop_pos(stop_reg[(i == 0) ? 0 : i - 1])};
                for (int c = 0; c < NUM_CH; c++) begin
                    up_rgb[c] = stop_color(stop_reg[(i == 0) ? 0 : i - 1], c);
                end
            end
            for (int c = 0; c < NUM_CH; c++) begin
                lo_rgb[c] = stop_color(stop_reg[i], c);
            end
            if ((CNT_W'(i) < cnt_lim) && (s_ratio >= pos)) begin
                s1_next.matched = 1'b1;
                s1_next.t       = s_ratio - pos;
                s1_next.span    = $signed({1'b0, up_pos}) - $signed({2'b0, pos});
                s1_next.direct  = ({1'b0, up_pos} == {2'b0, pos});
                s1_next.lower   = lo_rgb;
                s1_next.upper   = up_rgb;
            end
        end
    end

    // Stage 2: t * (upper - lower) and lower * span
    always_comb begin
        logic signed [PROD_W-1:0] t_s;
        logic signed [PROD_W-1:0] d_s;
        logic signed [PROD_W-1:0] l_s;
        logic signed [PROD_W-1:0] sp_s;
        t_s  = PROD_W'($signed({1'b0, s1_reg.t}));
        sp_s = PROD_W'(s1_reg.span);
        s2_next.matched = s1_reg.matched;
        s2_next.direct  = s1_reg.direct;
        s2_next.lower   = s1_reg.lower;
        s2_next.span    = s1_reg.span;
        for (int c = 0; c < NUM_CH; c++) begin
            d_s = PROD_W'($signed({1'b0, s1_reg.upper[c]}) - $signed({1'b0, s1_reg.lower[c]}));
            l_s = PROD_W'($signed({1'b0, s1_reg.lower[c]}));
            s2_next.p_slope[c] = t_s * d_s;
            s2_next.p_base[c]  = l_s * sp_s;
        end
    end

    // Stage 3: numerator, signs and magnitudes
    always_comb begin
        logic signed [PROD_W-1:0] n_s;
        logic                     d_neg;
        d_neg = s2_reg.span[SPAN_W-1];
        s3_next.matched = s2_reg.matched;
        s3_next.direct  = s2_reg.direct;
        s3_next.lower   = s2_reg.lower;
        s3_next.den     = DEN_W'(d_neg ? -s2_reg.span : s2_reg.span);
        for (int c = 0; c < NUM_CH; c++) begin
            n_s = $signed(s2_reg.p_slope[c]) + $signed(s2_reg.p_base[c]);
            // opposite signs give a negative floor, clamped to zero
            s3_next.zero[c] = n_s[PROD_W-1] ^ d_neg;
            s3_next.num[c]  = REM_W'(n_s[PROD_W-1] ? -n_s : n_s);
        end
    end

    // Stage 4: saturation check and quotient bits 7..4
    always_comb begin
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] dsh;
        s4_next.matched = s3_reg.matched;
        s4_next.direct  = s3_reg.direct;
        s4_next.lower   = s3_reg.lower;
        s4_next.zero    = s3_reg.zero;
        s4_next.den     = s3_reg.den;
        for (int c = 0; c < NUM_CH; c++) begin
            r = s3_reg.num[c];
            s4_next.over[c] = (r >= (REM_W'(s3_reg.den) << QUO_W));
            for (int b = QUO_W - 1; b >= HALF_Q; b--) begin
                dsh = REM_W'(s3_reg.den) << b;
                s4_next.quo_hi[c][b - HALF_Q] = (r >= dsh);
                if (r >= dsh) begin
                    r = r - dsh;
                end
            end
            s4_next.rem[c] = r;
        end
    end

    // Stage 5: quotient bits 3..0 and output select
    always_comb begin
        logic [REM_W-1:0]  r;
        logic [REM_W-1:0]  dsh;
        logic [HALF_Q-1:0] quo_lo;
        for (int c = 0; c < NUM_CH; c++) begin
            r = s4_reg.rem[c];
            for (int b = HALF_Q - 1; b >= 0; b--) begin
                dsh = REM_W'(s4_reg.den) << b;
                quo_lo[b] = (r >= dsh);
                if (r >= dsh) begin
                    r = r - dsh;
                end
            end
            priority if (s4_reg.direct) begin
                out_rgb_next[c] = s4_reg.lower[c];
            end else if (s4_reg.zero[c]) begin
                out_rgb_next[c] = '0;
            end else if (s4_reg.over[c]) begin
                out_rgb_next[c] = '1;
            end else begin
                out_rgb_next[c] = {s4_reg.quo_hi[c], quo_lo};
            end
        end
    end

    // Stage payload registers
    always_ff @(posedge aclk) begin
        if (rdy[0] && s_valid) begin
            s1_reg <= s1_next;
        end
        if (rdy[1] && valid_reg[0]) begin
            s2_reg <= s2_next;
        end
        if (rdy[2] && valid_reg[1]) begin
            s3_reg <= s3_next;
        end
        if (rdy[3] && valid_reg[2]) begin
            s4_reg <= s4_next;
        end
        if (rdy[4] && valid_reg[3]) begin
            out_rgb_reg     <= out_rgb_next;
            out_matched_reg <= s4_reg.matched;
        end
    end

    assign m_valid   = valid_reg[NSTG-1];
    assign m_red     = out_rgb_reg[CH_RED];
    assign m_green   = out_rgb_reg[CH_GREEN];
    assign m_blue    = out_rgb_reg[CH_BLUE];
    assign m_matched = out_matched_reg;

    // Checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ((&valid_reg) && !m_ready))
        else $error("input stalled while the pipeline has a free slot");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[0] && rdy[1]) |=> valid_reg[1])
        else $error("word lost between stage one and stage two");

endmodule
